[design/dpsr_pkg.sv]
package dpsr_pkg;

  // register map (index = paddr / 4)
  localparam logic REG_LATCH_TICKS = 1'b0;
  localparam logic REG_HALF_PERIOD = 1'b1;

  localparam logic [7:0] LATCH_TICKS_RST = 8'd12;
  localparam logic [7:0] HALF_PERIOD_RST = 8'd6;

  localparam logic [7:0] AXIS_CENTER = 8'd128;
  localparam logic [7:0] AXIS_MAX    = 8'd255;
  localparam logic [7:0] AXIS_MIN    = 8'd0;
  localparam logic [7:0] SHORT_BYTE  = 8'hFF;

  localparam logic [4:0] FIRST_BYTE_LAST = 5'd7;
  localparam logic [4:0] BITS_PER_READ   = 5'd16;

  localparam int unsigned QUEUE_DEPTH = 2;

  // one tick word after the front end: pins already turned into pressed bits
  typedef struct packed {
    logic poll;
    logic pressed_one;
    logic pressed_two;
  } item_t;

  typedef struct packed {
    logic       latch_drive;
    logic       clock_drive;
    logic       report_ready;
    logic       report_changed;
    logic [7:0] axis_x;
    logic [7:0] axis_y;
    logic [7:0] button_bits;
    logic       short_pad_one;
    logic       short_pad_two;
  } report_t;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_LATCH = 5'b00010,
    PH_HIGH  = 5'b00100,
    PH_LOW   = 5'b01000,
    PH_DONE  = 5'b10000
  } phase_t;

endpackage

[design/dpsr_front.sv]
module dpsr_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_poll_start,
  input  logic           in_pad_one_pin,
  input  logic           in_pad_two_pin,
  output logic           q_valid,
  output dpsr_pkg::item_t q_item,
  input  logic           q_pop
);

  dpsr_pkg::item_t slot_r [dpsr_pkg::QUEUE_DEPTH];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push;
  dpsr_pkg::item_t push_item;

  assign in_ready = (cnt_r != 2'(dpsr_pkg::QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];

  // pins are active low: 0 means pressed
  always_comb begin
    push_item.poll        = in_poll_start;
    push_item.pressed_one = ~in_pad_one_pin;
    push_item.pressed_two = ~in_pad_two_pin;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[design/dpsr_back.sv]
module dpsr_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       latch_ticks,
  input  logic [7:0]       half_period_ticks,
  input  logic             q_valid,
  input  dpsr_pkg::item_t  q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output dpsr_pkg::report_t out_word
);

  dpsr_pkg::phase_t phase_r, phase_nxt, ph;
  logic [7:0]  tick_r, tick_nxt, tc, tc_inc;
  logic [4:0]  bit_r, bit_nxt, bi;
  logic [7:0]  shift_one_r, shift_one_nxt;
  logic [7:0]  shift_two_r, shift_two_nxt;
  logic [7:0]  rb0_r, rb0_nxt, rb1_r, rb1_nxt, rb2_r, rb2_nxt, rb3_r, rb3_nxt;
  logic [31:0] reported_r, reported_nxt;
  logic [1:0]  short_r, short_nxt;
  logic        out_valid_r, out_valid_nxt;
  dpsr_pkg::report_t word_r, word_nxt;

  function automatic logic [7:0] pad_buttons(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic is_short);
    logic [7:0] v;
    if (is_short) begin
      v = {b0[5], 2'b00, b0[7], b0[6], 2'b00, b0[4]};
    end else begin
      v = {b0[5], b1[3], b1[2], b1[0], b0[7], b1[1], b0[6], b0[4]};
    end
    return v;
  endfunction

  // plus pushes toward max (or back to center from min), minus the other way
  function automatic logic [7:0] axis_apply(input logic [7:0] a, input logic plus,
                                            input logic minus);
    logic [7:0] v;
    v = a;
    if (plus) begin
      v = (v != dpsr_pkg::AXIS_MIN) ? dpsr_pkg::AXIS_MAX : dpsr_pkg::AXIS_CENTER;
    end
    if (minus) begin
      v = (v == dpsr_pkg::AXIS_MAX) ? dpsr_pkg::AXIS_CENTER : dpsr_pkg::AXIS_MIN;
    end
    return v;
  endfunction

  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_word  = word_r;

  always_comb begin
    ph            = phase_r;
    tc            = tick_r;
    bi            = bit_r;
    shift_one_nxt = shift_one_r;
    shift_two_nxt = shift_two_r;
    rb0_nxt       = rb0_r;
    rb1_nxt       = rb1_r;
    rb2_nxt       = rb2_r;
    rb3_nxt       = rb3_r;
    reported_nxt  = reported_r;
    short_nxt     = short_r;

    word_nxt.latch_drive    = 1'b0;
    word_nxt.clock_drive    = 1'b1;
    word_nxt.report_ready   = 1'b0;
    word_nxt.report_changed = 1'b0;
    word_nxt.axis_x         = dpsr_pkg::AXIS_CENTER;
    word_nxt.axis_y         = dpsr_pkg::AXIS_CENTER;
    word_nxt.button_bits    = 8'd0;

    if (ph == dpsr_pkg::PH_IDLE && q_item.poll) begin
      ph            = dpsr_pkg::PH_LATCH;
      tc            = 8'd0;
      bi            = 5'd0;
      shift_one_nxt = 8'd0;
      shift_two_nxt = 8'd0;
    end

    tc_inc    = tc + 8'd1;
    phase_nxt = ph;
    tick_nxt  = tc;
    bit_nxt   = bi;

    case (ph)
      dpsr_pkg::PH_IDLE: begin
        phase_nxt = dpsr_pkg::PH_IDLE;
      end
      dpsr_pkg::PH_LATCH: begin
        word_nxt.latch_drive = 1'b1;
        tick_nxt = tc_inc;
        if (tc_inc >= latch_ticks) begin
          phase_nxt = dpsr_pkg::PH_HIGH;
          tick_nxt  = 8'd0;
        end
      end
      dpsr_pkg::PH_HIGH: begin
        tick_nxt = tc_inc;
        if (tc_inc >= half_period_ticks) begin
          phase_nxt = dpsr_pkg::PH_LOW;
          tick_nxt  = 8'd0;
        end
      end
      dpsr_pkg::PH_LOW: begin
        word_nxt.clock_drive = 1'b0;
        if (tc == 8'd0) begin
          if (bi < 5'd8) begin
            shift_one_nxt = {shift_one_r[6:0], q_item.pressed_one};
            shift_two_nxt = {shift_two_r[6:0], q_item.pressed_two};
            if (bi == dpsr_pkg::FIRST_BYTE_LAST) begin
              rb0_nxt = {shift_one_r[6:0], q_item.pressed_one};
              rb2_nxt = {shift_two_r[6:0], q_item.pressed_two};
            end
          end else begin
            shift_one_nxt = {q_item.pressed_one, shift_one_r[7:1]};
            shift_two_nxt = {q_item.pressed_two, shift_two_r[7:1]};
          end
        end
        tick_nxt = tc_inc;
        if (tc_inc >= half_period_ticks) begin
          tick_nxt  = 8'd0;
          bit_nxt   = bi + 5'd1;
          phase_nxt = ((bi + 5'd1) >= dpsr_pkg::BITS_PER_READ) ? dpsr_pkg::PH_DONE
                                                               : dpsr_pkg::PH_HIGH;
        end
      end
      dpsr_pkg::PH_DONE: begin
        short_nxt[0] = (shift_one_r == dpsr_pkg::SHORT_BYTE);
        short_nxt[1] = (shift_two_r == dpsr_pkg::SHORT_BYTE);
        rb1_nxt = short_nxt[0] ? 8'd0 : shift_one_r;
        rb3_nxt = short_nxt[1] ? 8'd0 : shift_two_r;
        word_nxt.report_changed = ({rb3_nxt, rb2_r, rb1_nxt, rb0_r} != reported_r);
        word_nxt.button_bits = pad_buttons(rb0_r, rb1_nxt, short_nxt[0])
                             | pad_buttons(rb2_r, rb3_nxt, short_nxt[1]);
        word_nxt.axis_x = axis_apply(axis_apply(dpsr_pkg::AXIS_CENTER, rb0_r[0], rb0_r[1]),
                                     rb2_r[0], rb2_r[1]);
        word_nxt.axis_y = axis_apply(axis_apply(dpsr_pkg::AXIS_CENTER, rb0_r[2], rb0_r[3]),
                                     rb2_r[2], rb2_r[3]);
        reported_nxt = {rb3_nxt, rb2_r, rb1_nxt, rb0_r};
        word_nxt.report_ready = 1'b1;
        phase_nxt = dpsr_pkg::PH_IDLE;
        tick_nxt  = 8'd0;
        bit_nxt   = 5'd0;
      end
      default: begin
        phase_nxt = dpsr_pkg::PH_IDLE;
      end
    endcase

    word_nxt.short_pad_one = short_nxt[0];
    word_nxt.short_pad_two = short_nxt[1];

    out_valid_nxt = q_pop ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= dpsr_pkg::PH_IDLE;
      tick_r      <= 8'd0;
      bit_r       <= 5'd0;
      shift_one_r <= 8'd0;
      shift_two_r <= 8'd0;
      rb0_r       <= 8'd0;
      rb1_r       <= 8'd0;
      rb2_r       <= 8'd0;
      rb3_r       <= 8'd0;
      reported_r  <= 32'd0;
      short_r     <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        phase_r     <= phase_nxt;
        tick_r      <= tick_nxt;
        bit_r       <= bit_nxt;
        shift_one_r <= shift_one_nxt;
        shift_two_r <= shift_two_nxt;
        rb0_r       <= rb0_nxt;
        rb1_r       <= rb1_nxt;
        rb2_r       <= rb2_nxt;
        rb3_r       <= rb3_nxt;
        reported_r  <= reported_nxt;
        short_r     <= short_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      word_r <= word_nxt;
    end
  end

endmodule

[design/dual_pad_serial_reader_core.sv]
// Two-pad serial button reader. Each input word is one timebase tick (nominally
// 1 us) carrying a poll request and the two active-low pad data pins; each tick
// yields exactly one output word with the latch and clock line levels for that
// tick, plus the merged report on the tick a read completes. Sustained rate is
// one word per clock cycle while out_ready stays high: a 2-entry input queue
// feeds the tick engine, which retires one tick per cycle into an output
// register whenever that register is empty or being taken. An accepted word is
// written into the queue, then registered into the output register that drives
// out_* when the engine pops it. Latch and clock phase lengths come from the
// APB registers latch_ticks (0x0, reset 12) and half_period_ticks (0x4, reset
// 6); a value of 0 behaves as 1. Write them only while no read is in progress.
module dual_pad_serial_reader_core (
  input  logic        clk,
  input  logic        rst_n,
  // input tick words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_poll_start,
  input  logic        in_pad_one_pin,
  input  logic        in_pad_two_pin,
  // output words
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_latch_drive,
  output logic        out_clock_drive,
  output logic        out_report_ready,
  output logic        out_report_changed,
  output logic [7:0]  out_axis_x,
  output logic [7:0]  out_axis_y,
  output logic [7:0]  out_button_bits,
  output logic        out_short_pad_one,
  output logic        out_short_pad_two,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] latch_ticks_r, latch_ticks_nxt;
  logic [7:0] half_period_r, half_period_nxt;
  logic       reg_wr;
  logic       reg_idx;

  logic              q_valid;
  logic              q_pop;
  dpsr_pkg::item_t   q_item;
  dpsr_pkg::report_t word;

  // --- register port: write in the access phase, reads are combinational
  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_comb begin
    latch_ticks_nxt = latch_ticks_r;
    half_period_nxt = half_period_r;
    if (reg_wr) begin
      case (reg_idx)
        dpsr_pkg::REG_LATCH_TICKS: latch_ticks_nxt = pwdata[7:0];
        dpsr_pkg::REG_HALF_PERIOD: half_period_nxt = pwdata[7:0];
        default: ;
      endcase
    end
    case (reg_idx)
      dpsr_pkg::REG_LATCH_TICKS: prdata = {24'd0, latch_ticks_r};
      dpsr_pkg::REG_HALF_PERIOD: prdata = {24'd0, half_period_r};
      default:                   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_ticks_r <= dpsr_pkg::LATCH_TICKS_RST;
      half_period_r <= dpsr_pkg::HALF_PERIOD_RST;
    end else begin
      latch_ticks_r <= latch_ticks_nxt;
      half_period_r <= half_period_nxt;
    end
  end

  // --- front: accept tick words, decode pins, queue them
  dpsr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_poll_start  (in_poll_start),
    .in_pad_one_pin (in_pad_one_pin),
    .in_pad_two_pin (in_pad_two_pin),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  // --- back: latch/clock sequencer, shifters, report merge, output register
  dpsr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .latch_ticks       (latch_ticks_r),
    .half_period_ticks (half_period_r),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_word          (word)
  );

  assign out_latch_drive    = word.latch_drive;
  assign out_clock_drive    = word.clock_drive;
  assign out_report_ready   = word.report_ready;
  assign out_report_changed = word.report_changed;
  assign out_axis_x         = word.axis_x;
  assign out_axis_y         = word.axis_y;
  assign out_button_bits    = word.button_bits;
  assign out_short_pad_one  = word.short_pad_one;
  assign out_short_pad_two  = word.short_pad_two;

  // --- checks

  // latch high and clock low never share a tick
  a_latch_clock_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_latch_drive && !out_clock_drive))
    else $error("latch and clock low in the same tick");

  // a completing tick has the clock back high and the latch released
  a_report_lines: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_report_ready) |-> (out_clock_drive && !out_latch_drive))
    else $error("report on a tick with active latch or clock");

  // without a report, the payload sits at its neutral values
  a_idle_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_report_ready) |->
      (!out_report_changed && out_axis_x == dpsr_pkg::AXIS_CENTER &&
       out_axis_y == dpsr_pkg::AXIS_CENTER && out_button_bits == 8'd0))
    else $error("report fields set on a non-report tick");

  // the engine only pulls from the queue when it holds a word
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule
